// ----- rtl/core/lewc_pkg.sv -----
`timescale 1ns / 1ps
package lewc_pkg;

  // One input request: a sensor sample and its time stamp.
  typedef struct packed {
    logic signed [15:0] sample;
    logic [31:0]        time_tag;
  } in_item_t;

  // One window item on the result channel.
  typedef struct packed {
    logic signed [15:0] sample_out;
    logic [31:0]        event_time;
    logic [3:0]         position;
    logic               last;
  } out_item_t;

  // Queue between the window sequencer and the output stage (power of two).
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // Configuration port.
  localparam int                 CFG_AW         = 3;
  localparam logic               REG_LOUD_LEVEL = 1'b0;
  localparam logic signed [15:0] LOUD_LEVEL_RST = 16'sd3000;

endpackage

// ----- rtl/core/loud_event_window_capture.sv -----
`timescale 1ns / 1ps
// Results: no result for a sample except the one after the post window; its first window
//   item reaches out_valid through the sequencer, the queue and the result register, the rest
//   one per cycle while out_ready is high. Input: one sample per cycle; after the emitting
//   sample in_ready stays low while the window sequencer drains its RING_DEPTH-1+POST_COUNT
//   items (10 by default), longer while the result side stalls with the queue full.
// Reset: rst_n synchronous, active low; clears control, loud_level returns to 3000.
module loud_event_window_capture #(
  parameter int RING_DEPTH = 6,
  parameter int POST_COUNT = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lewc_pkg::in_item_t            in_data,
  // window channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output lewc_pkg::out_item_t           out_data,
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lewc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  // ---------------------------------------------------------------
  // Configuration: one register, loud_level, at byte address 0.
  // Bit 2 of paddr selects the register word; anything else is ignored.
  // ---------------------------------------------------------------
  logic signed [15:0] loud_level_r, loud_level_nxt;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    loud_level_nxt = loud_level_r;
    cfg_prdata     = '0;
    unique case (cfg_paddr[2])
      lewc_pkg::REG_LOUD_LEVEL: begin
        cfg_prdata = {{16{loud_level_r[15]}}, loud_level_r};
        if (cfg_wr) begin
          loud_level_nxt = cfg_pwdata[15:0];
        end
      end
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loud_level_r <= lewc_pkg::LOUD_LEVEL_RST;
    end else begin
      loud_level_r <= loud_level_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Front: history line, trigger / rearm tracking, window capture,
  // and the sequencer that pushes the finished window one item a cycle while the queue is not full.
  // ---------------------------------------------------------------
  logic                push_valid, push_full;
  lewc_pkg::out_item_t push_item;

  lewc_front #(
    .RING_DEPTH (RING_DEPTH),
    .POST_COUNT (POST_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .loud_level (loud_level_r),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_full  (push_full)
  );

  // ---------------------------------------------------------------
  // Short queue so a stalled result side does not stop the sequencer
  // until it is full.
  // ---------------------------------------------------------------
  logic                q_pop, q_empty;
  lewc_pkg::out_item_t q_head;

  lewc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (push_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // ---------------------------------------------------------------
  // Back: registered result stage.
  // ---------------------------------------------------------------
  lewc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/lewc_front.sv -----
`timescale 1ns / 1ps
module lewc_front #(
  parameter int RING_DEPTH = 6,
  parameter int POST_COUNT = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  lewc_pkg::in_item_t      in_data,
  input  logic signed [15:0]      loud_level,
  output logic                    push_valid,
  output lewc_pkg::out_item_t     push_item,
  input  logic                    push_full
);

  localparam int PRE = RING_DEPTH - 1;
  localparam int NUM = PRE + POST_COUNT;
  localparam int FW  = $clog2(PRE + 1);
  localparam int PW  = $clog2(POST_COUNT + 1);
  localparam int IW  = ($clog2(NUM) > 4) ? $clog2(NUM) : 4;

  logic signed [15:0] hist_r [PRE];
  logic signed [15:0] pre_r  [PRE];
  logic signed [15:0] post_r [POST_COUNT];
  logic [31:0]        held_time_r;

  logic [FW-1:0] fill_r, fill_nxt;
  logic          found_r, found_nxt;
  logic          capt_r, capt_nxt;
  logic [PW-1:0] post_left_r, post_left_nxt;
  logic          drain_r, drain_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  logic accept, loud, full_after, trig, post_take, idx_last;

  assign in_ready   = !drain_r;
  assign accept     = in_valid && in_ready;
  assign loud       = (in_data.sample >= loud_level);
  // ring holds PRE samples once this push lands
  assign full_after = (fill_r >= FW'(PRE - 1));
  assign push_valid = drain_r && !push_full;
  assign idx_last   = (idx_r == IW'(NUM - 1));

  always_comb begin
    fill_nxt      = fill_r;
    found_nxt     = found_r;
    capt_nxt      = capt_r;
    post_left_nxt = post_left_r;
    drain_nxt     = drain_r;
    idx_nxt       = idx_r;
    trig          = 1'b0;
    post_take     = 1'b0;
    if (accept) begin
      if (fill_r != FW'(PRE)) begin
        fill_nxt = fill_r + 1'b1;
      end
      if (!capt_r) begin
        if (loud && !found_r) begin
          found_nxt = 1'b1;
          if (full_after) begin
            trig          = 1'b1;
            capt_nxt      = 1'b1;
            post_left_nxt = PW'(POST_COUNT);
          end
        end else if (!loud && found_r) begin
          found_nxt = 1'b0;
        end
      end else if (post_left_r != '0) begin
        post_take     = 1'b1;
        post_left_nxt = post_left_r - 1'b1;
      end else begin
        // sample after the post window: hand the window to the output side
        capt_nxt  = 1'b0;
        drain_nxt = 1'b1;
        idx_nxt   = '0;
      end
    end
    if (push_valid) begin
      idx_nxt = idx_r + 1'b1;
      if (idx_last) begin
        drain_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      found_r     <= 1'b0;
      capt_r      <= 1'b0;
      post_left_r <= '0;
      drain_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      fill_r      <= fill_nxt;
      found_r     <= found_nxt;
      capt_r      <= capt_nxt;
      post_left_r <= post_left_nxt;
      drain_r     <= drain_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // History shift line, window capture and window drain.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < PRE - 1; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
      hist_r[PRE-1] <= in_data.sample;
    end
    if (trig) begin
      for (int i = 0; i < PRE - 1; i++) begin
        pre_r[i] <= hist_r[i+1];
      end
      pre_r[PRE-1] <= in_data.sample;
      held_time_r  <= in_data.time_tag;
    end
    if (post_take) begin
      for (int j = 0; j < POST_COUNT - 1; j++) begin
        post_r[j] <= post_r[j+1];
      end
      post_r[POST_COUNT-1] <= in_data.sample;
    end
    if (push_valid) begin
      // pre and post form one chain; the head leaves each push
      for (int i = 0; i < PRE - 1; i++) begin
        pre_r[i] <= pre_r[i+1];
      end
      pre_r[PRE-1] <= post_r[0];
      for (int j = 0; j < POST_COUNT - 1; j++) begin
        post_r[j] <= post_r[j+1];
      end
    end
  end

  always_comb begin
    push_item.sample_out = pre_r[0];
    push_item.event_time = held_time_r;
    push_item.position   = idx_r[3:0];
    push_item.last       = idx_last;
  end

endmodule

// ----- rtl/core/lewc_fifo.sv -----
`timescale 1ns / 1ps
module lewc_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  lewc_pkg::out_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output lewc_pkg::out_item_t head
);

  lewc_pkg::out_item_t mem_r [lewc_pkg::FIFO_DEPTH];

  logic [lewc_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [lewc_pkg::FIFO_AW:0]   count_r;
  logic                         do_push, do_pop;

  assign full    = (count_r == (lewc_pkg::FIFO_AW + 1)'(lewc_pkg::FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push_valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/core/lewc_back.sv -----
`timescale 1ns / 1ps
module lewc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                empty,
  input  lewc_pkg::out_item_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lewc_pkg::out_item_t out_data
);

  logic                out_valid_r, out_valid_nxt;
  lewc_pkg::out_item_t out_data_r;

  // refill when the register is empty or its item leaves this cycle
  assign pop           = !empty && (!out_valid_r || out_ready);
  assign out_valid_nxt = pop || (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= head;
    end
  end

endmodule

// ----- rtl/core/lewc_checker.sv -----
`timescale 1ns / 1ps
module lewc_checker #(
  parameter int RING_DEPTH = 6,
  parameter int POST_COUNT = 5
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input lewc_pkg::out_item_t out_data
);

  localparam int NUM = RING_DEPTH - 1 + POST_COUNT;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // window closes on its final position
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.position == 4'(NUM - 1))
    else $error("last flag on wrong position");

  // a window drains without bubbles once started
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=> out_valid)
    else $error("gap inside window");

  // reset empties the result stage
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind loud_event_window_capture lewc_checker #(
  .RING_DEPTH (RING_DEPTH),
  .POST_COUNT (POST_COUNT)
) u_checker (.*);

// ----- sim/loud_event_window_capture_tb.sv -----
`timescale 1ns / 1ps
module loud_event_window_capture_tb;

  // Block geometry, kept at the defaults of the instance below.
  localparam int RING_DEPTH = 6;
  localparam int POST_COUNT = 5;
  localparam int PRE_COUNT  = RING_DEPTH - 1;
  localparam int WINDOW_LEN = PRE_COUNT + POST_COUNT;

  localparam int CFG_AW = lewc_pkg::CFG_AW;

  // Register map: register i at byte address 4*i; index 1 is unmapped.
  localparam int                REG_UNMAPPED    = 1;
  localparam logic [CFG_AW-1:0] ADDR_LOUD_LEVEL = CFG_AW'(4 * lewc_pkg::REG_LOUD_LEVEL);
  localparam logic [CFG_AW-1:0] ADDR_UNMAPPED   = CFG_AW'(4 * REG_UNMAPPED);

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 8;    // margin for samples still in flight
  localparam int HOLD_CYCLES   = 150;  // long receiver stall to back the block up
  localparam int NUM_PHASES    = 5;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  lewc_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lewc_pkg::out_item_t out_data;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  loud_event_window_capture #(
    .RING_DEPTH(RING_DEPTH),
    .POST_COUNT(POST_COUNT)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Capture predictor: shadow ring, trigger flags and window buffers.
  // ---------------------------------------------------------------------------
  logic [15:0]        hist_ring [RING_DEPTH];
  int unsigned        rd_slot;
  int unsigned        wr_slot;
  bit                 found_m;
  bit                 capturing_m;
  int unsigned        post_left_m;
  logic [15:0]        pre_buf [PRE_COUNT];
  logic [15:0]        post_buf [POST_COUNT];
  logic [31:0]        trig_tag;
  logic signed [15:0] level_m;

  lewc_pkg::out_item_t window_due [$];     // window items predicted, not yet seen
  lewc_pkg::in_item_t  sample_backlog [$]; // sample requests waiting for the driver

  int  issued_cnt = 0;
  int  accepted_cnt = 0;
  int  result_cnt = 0;
  int  window_cnt = 0;
  int  cfg_write_cnt = 0;
  int  fail_cnt = 0;
  int  cycle_cnt = 0;
  bit  in_fire = 1'b0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_seq = 0;
  int  hold_seen = 0;
  int  hold_left = 0;

  function automatic int unsigned ring_next(int unsigned s);
    return (s + 1) % RING_DEPTH;
  endfunction

  function automatic bit ring_is_full();
    return rd_slot == ring_next(wr_slot);
  endfunction

  function automatic void capture_model_reset();
    rd_slot     = 0;
    wr_slot     = 0;
    found_m     = 1'b0;
    capturing_m = 1'b0;
    post_left_m = 0;
    trig_tag    = '0;
    level_m     = lewc_pkg::LOUD_LEVEL_RST;
  endfunction

  // One accepted sample request; queues the window items it releases.
  function automatic void capture_model_step(lewc_pkg::in_item_t req);
    lewc_pkg::out_item_t item;
    int unsigned         r;
    hist_ring[wr_slot] = req.sample;
    if (ring_is_full()) rd_slot = ring_next(rd_slot);
    wr_slot = ring_next(wr_slot);
    if (!capturing_m) begin
      if ($signed(req.sample) >= $signed(level_m) && !found_m) begin
        found_m = 1'b1;
        // trigger with a short ring only sets found
        if (ring_is_full()) begin
          capturing_m = 1'b1;
          trig_tag    = req.time_tag;
          r           = rd_slot;
          for (int i = 0; i < PRE_COUNT; i++) begin
            pre_buf[i] = hist_ring[r];
            r = ring_next(r);
          end
          post_left_m = POST_COUNT;
        end
      end else if ($signed(req.sample) < $signed(level_m) && found_m) begin
        found_m = 1'b0;
      end
    end else if (post_left_m > 0) begin
      // trigger and rearm frozen while collecting
      post_buf[POST_COUNT - post_left_m] = req.sample;
      post_left_m--;
    end else begin
      // emitting sample: goes into the ring only, no trigger check
      capturing_m = 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        item.sample_out = (i < PRE_COUNT) ? pre_buf[i] : post_buf[i - PRE_COUNT];
        item.event_time = trig_tag;
        item.position   = 4'(i);
        item.last       = (i == WINDOW_LEN - 1);
        window_due.push_back(item);
      end
    end
  endfunction

  task automatic check_field(string name, logic [32:0] expv, logic [32:0] actv);
    if (actv !== expv) begin
      $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, name, expv, actv);
      fail_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Rising edge: accept sample requests into the predictor, check window items.
  // Everything here reads pre-edge values, so there is no ordering race.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lewc_pkg::out_item_t due_item;
    in_fire = in_valid && in_ready;
    if (rst_n && in_fire) begin
      capture_model_step(in_data);
      accepted_cnt++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (window_due.size() == 0) begin
        $display("%0t: window item with nothing due: %p", $time, out_data);
        fail_cnt++;
      end else begin
        due_item = window_due.pop_front();
        check_field("sample_out", due_item.sample_out, out_data.sample_out);
        check_field("event_time", due_item.event_time, out_data.event_time);
        check_field("position",   due_item.position,   out_data.position);
        check_field("last",       due_item.last,       out_data.last);
        result_cnt++;
        if (due_item.last) window_cnt++;
      end
    end
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d requests accepted, %0d items due", $time,
               accepted_cnt, issued_cnt, window_due.size());
      $display("status: fail");
      $finish;
    end
  end

  // Sender: offers the next request at the falling edge, holds until accepted.
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (sample_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= sample_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off each time hold_seq moves.
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_sample(logic signed [15:0] s, logic [31:0] tag);
    lewc_pkg::in_item_t req;
    req.sample   = s;
    req.time_tag = tag;
    sample_backlog.push_back(req);
    issued_cnt++;
  endtask

  // A sample below the level, often just below it.
  function automatic logic signed [15:0] quiet_value(logic signed [15:0] lvl);
    int hi;
    hi = int'(lvl) - 1;
    if (hi < -32768) return 16'($urandom());  // nothing can be quiet
    if ($urandom_range(1))
      return 16'(hi - int'($urandom_range((hi + 32768 < 64) ? hi + 32768 : 64)));
    return 16'(-32768 + int'($urandom_range(hi + 32768)));
  endfunction

  // A sample at or above the level, often right at it.
  function automatic logic signed [15:0] trig_value(logic signed [15:0] lvl);
    int lo;
    int span;
    lo   = int'(lvl);
    span = 32767 - lo;
    if ($urandom_range(1)) return 16'(lo + int'($urandom_range((span < 64) ? span : 64)));
    return 16'(lo + int'($urandom_range(span)));
  endfunction

  // Mostly rearm / trigger / post / emit sequences with random content,
  // some raw noise and some cut-short sequences.
  task automatic add_phase_samples(int count, logic signed [15:0] lvl);
    int stop_at;
    int kind;
    int n;
    stop_at = issued_cnt + count;
    while (issued_cnt < stop_at) begin
      kind = $urandom_range(9);
      if (kind < 2) begin
        n = $urandom_range(6, 1);
        repeat (n) add_sample(16'($urandom()), $urandom());
      end else begin
        n = $urandom_range(4, 1);
        repeat (n) add_sample(quiet_value(lvl), $urandom());
        add_sample(trig_value(lvl), $urandom());
        n = (kind == 2) ? $urandom_range(POST_COUNT) : POST_COUNT + 1;
        repeat (n) begin
          if ($urandom_range(1)) add_sample(trig_value(lvl), $urandom());
          else add_sample(16'($urandom()), $urandom());
        end
      end
    end
  endtask

  // Wait for every request accepted and every window item seen, then let
  // in-flight samples settle before the level may change.
  task automatic wait_drained();
    while (accepted_cnt != issued_cnt || window_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [31:0] data);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == ADDR_LOUD_LEVEL) level_m = data[15:0];  // other indexes ignored
    cfg_write_cnt++;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Read back loud_level and compare its low half with the shadow copy.
  task automatic cfg_check_level();
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = ADDR_LOUD_LEVEL;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    check_field("loud_level readback", $unsigned(level_m), cfg_prdata[15:0]);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic signed [15:0] phase_level [NUM_PHASES];
    int                 phase_count [NUM_PHASES];
    capture_model_reset();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    cfg_check_level();                     // reset value
    cfg_write(ADDR_LOUD_LEVEL, 32'(lewc_pkg::LOUD_LEVEL_RST));
    cfg_write(ADDR_UNMAPPED, $urandom());  // must not touch loud_level
    cfg_check_level();

    send_idle_pct = 17;
    recv_idle_pct = 68;

    // Directed part at the reset level of 3000.
    add_sample(16'sd32767, 32'h0000_0000);   // loud before the ring fills: found only
    add_sample(16'sd32767, 32'h0000_0001);   // still found, no retrigger
    add_sample(-16'sd32768, 32'h0000_0002);  // rearm
    add_sample(16'sd0, 32'h0000_0003);
    add_sample(16'sd2999, 32'h0000_0004);    // one below the level
    add_sample(16'sd3000, 32'hFFFF_FFFF);    // exactly at the level, ring full: capture
    add_sample(16'sd32767, 32'h0000_0006);   // loud during capture, ignored
    add_sample(-16'sd32768, 32'h0000_0007);  // quiet during capture, no rearm
    add_sample(-16'sd1, 32'h0000_0008);
    add_sample(16'sd3000, 32'h0000_0009);
    add_sample(16'sd1, 32'h0000_000A);
    add_sample(16'sd32767, 32'h0000_000B);   // emitting request, not checked
    add_sample(16'sd5000, 32'h0000_000C);    // found still set
    add_sample(-16'sd5, 32'h0000_000D);      // rearm
    add_sample(16'sd4000, 32'h8000_0000);    // second capture
    add_sample(16'sd2999, 32'h0000_000F);
    add_sample(16'sd3001, 32'h0000_0010);
    add_sample(-16'sd3000, 32'h0000_0011);
    add_sample(16'sd12345, 32'h0000_0012);
    add_sample(-16'sd12345, 32'h0000_0013);
    add_sample(-16'sd32768, 32'h0000_0014);  // quiet emitting request keeps found
    add_sample(-16'sd7, 32'h0000_0015);
    wait_drained();

    // Random phases: level extremes and random levels.
    phase_level[0] = 16'($urandom());
    phase_level[1] = 16'sd32767;
    phase_level[2] = -16'sd32768;
    phase_level[3] = 16'($urandom_range(2000) - 1000);
    phase_level[4] = 16'sd3000;
    phase_count[0] = 60;
    phase_count[1] = 40;
    phase_count[2] = 20;
    phase_count[3] = 70;
    phase_count[4] = 80;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 17;
        recv_idle_pct = 68;
      end else if (p < 4) begin
        send_idle_pct = 68;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cfg_write(ADDR_LOUD_LEVEL, 32'(phase_level[p]));
      cfg_check_level();
      add_phase_samples(phase_count[p], phase_level[p]);
      // last phase: stall the receiver while requests keep coming
      if (p == NUM_PHASES - 1) hold_seq++;
      wait_drained();
    end

    repeat (20) @(posedge clk);

    $display("covered %0d sample requests and %0d register writes over %0d levels;",
             accepted_cnt, cfg_write_cnt, NUM_PHASES + 1);
    $display("checked %0d windows (%0d items), %0d failures", window_cnt, result_cnt,
             fail_cnt);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
